// ===== rtl/core/qmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

	// Number format
	localparam int FRAC_BITS = 14;
	localparam int WORD_BITS = 16;

	// Operand lanes are one bit wider so that negating the most negative word is exact
	localparam int OP_W   = WORD_BITS + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int RND_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = RND_W + 2;

	// Action codes
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_QQ   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_QV   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ROTX = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ROTY = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ROTZ = 3'd4;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [OP_W-1:0]      op_t;
	typedef logic signed [RND_W-1:0]     rnd_t;
	typedef logic signed [SUM_W-1:0]     sum_t;

	// Hamilton product: component n takes p[k] * q[n ^ k]; these terms are subtracted
	function automatic logic term_neg(input logic [1:0] n, input logic [1:0] k);
		return (n == 2'd0 && k != 2'd0) || (n == 2'd1 && k == 2'd3) ||
		       (n == 2'd2 && k == 2'd1) || (n == 2'd3 && k == 2'd2);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qmr_rmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-stage multiplier: exact product, then round half up to FRAC_BITS fraction bits
module qmr_rmul (
	input  wire                  clk,
	input  wire qmr_pkg::op_t    a,
	input  wire qmr_pkg::op_t    b,
	output qmr_pkg::rnd_t        y
);
	import qmr_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_rnd;
	rnd_t                     y_s2;

	// full product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// add half lsb, drop fraction (arithmetic floor)
	assign prod_rnd = prod_s1 + HALF;

	always_ff @(posedge clk) begin
		y_s2 <= prod_rnd[PROD_W-1:FRAC_BITS];
	end

	assign y = y_s2;

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_multiply_rotate_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Quaternion multiply / rotate unit, signed Q2.14 fixed point.
// Input channel: action, a_w..a_z, b_w..b_z; a beat is taken at each clock edge
// with start high and busy low. busy stays low: a new beat may enter every cycle.
// Result channel: r_w..r_z and overflow, valid for the single cycle in which
// done is high; the receiver cannot hold results off, so none is needed.
// Actions: 0 Hamilton product A*B, 1 A times vector (0,Bx,By,Bz),
// 2/3/4 X/Y/Z axis rotated by A (r_w is zero), codes 5..7 give all zeros.
// The result beat passes through registered stages for operand select, product,
// rounding, four-term sum and saturation. Throughput: one beat per cycle, set by
// the sixteen pipelined multiplier lanes.
// Reset (arst_n low) clears all valid bits; beats in flight are dropped and
// no done pulse follows until new beats are accepted.
module quaternion_multiply_rotate_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [qmr_pkg::ACT_W-1:0]    action,
	input  wire  qmr_pkg::word_t         a_w,
	input  wire  qmr_pkg::word_t         a_x,
	input  wire  qmr_pkg::word_t         a_y,
	input  wire  qmr_pkg::word_t         a_z,
	input  wire  qmr_pkg::word_t         b_w,
	input  wire  qmr_pkg::word_t         b_x,
	input  wire  qmr_pkg::word_t         b_y,
	input  wire  qmr_pkg::word_t         b_z,
	output logic                         done,
	output qmr_pkg::word_t               r_w,
	output qmr_pkg::word_t               r_x,
	output qmr_pkg::word_t               r_y,
	output qmr_pkg::word_t               r_z,
	output logic                         overflow
);
	import qmr_pkg::*;

	localparam sum_t SAT_HI = {{(SUM_W-WORD_BITS){1'b0}}, 1'b0, {(WORD_BITS-1){1'b1}}};
	localparam sum_t SAT_LO = {{(SUM_W-WORD_BITS){1'b1}}, 1'b1, {(WORD_BITS-1){1'b0}}};

	function automatic op_t ext(input word_t w);
		return {w[WORD_BITS-1], w};
	endfunction

	op_t  p_in [4];
	op_t  q_in [4];
	logic rot_in;
	logic accept;

	op_t  p_s1 [4];
	op_t  q_s1 [4];
	rnd_t term [4][4];
	sum_t sum_c [4];
	sum_t sum_s4 [4];
	word_t r_s5 [4];
	logic ov_c [4];
	logic ov_s5;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rot_s1, rot_s2, rot_s3, rot_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// operand select: quaternion pair, or A*e and conj(A) for the rotations
	always_comb begin
		rot_in = 1'b0;
		for (int i = 0; i < 4; i++) begin
			p_in[i] = '0;
			q_in[i] = '0;
		end
		unique case (action)
			ACT_QQ, ACT_QV: begin
				p_in[0] = ext(a_w);
				p_in[1] = ext(a_x);
				p_in[2] = ext(a_y);
				p_in[3] = ext(a_z);
				q_in[0] = (action == ACT_QV) ? op_t'(0) : ext(b_w);
				q_in[1] = ext(b_x);
				q_in[2] = ext(b_y);
				q_in[3] = ext(b_z);
			end
			ACT_ROTX, ACT_ROTY, ACT_ROTZ: begin
				rot_in  = 1'b1;
				q_in[0] = ext(a_w);
				q_in[1] = -ext(a_x);
				q_in[2] = -ext(a_y);
				q_in[3] = -ext(a_z);
				if (action == ACT_ROTX) begin
					p_in[0] = -ext(a_x);
					p_in[1] = ext(a_w);
					p_in[2] = ext(a_z);
					p_in[3] = -ext(a_y);
				end else if (action == ACT_ROTY) begin
					p_in[0] = -ext(a_y);
					p_in[1] = -ext(a_z);
					p_in[2] = ext(a_w);
					p_in[3] = ext(a_x);
				end else begin
					p_in[0] = -ext(a_z);
					p_in[1] = ext(a_y);
					p_in[2] = -ext(a_x);
					p_in[3] = ext(a_w);
				end
			end
			default: begin
			end
		endcase
	end

	// valid and rotate flags travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		rot_s1 <= rot_in;
		rot_s2 <= rot_s1;
		rot_s3 <= rot_s2;
		rot_s4 <= rot_s3;
		for (int i = 0; i < 4; i++) begin
			p_s1[i] <= p_in[i];
			q_s1[i] <= q_in[i];
		end
	end

	// sixteen rounded products, component n term k = p[k] * q[n ^ k]
	for (genvar n = 0; n < 4; n++) begin : g_comp
		for (genvar k = 0; k < 4; k++) begin : g_term
			qmr_rmul u_rmul (
				.clk (clk),
				.a   (p_s1[k]),
				.b   (q_s1[n ^ k]),
				.y   (term[n][k])
			);
		end
	end

	// signed four-term sums
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			sum_c[n] = '0;
			for (int k = 0; k < 4; k++) begin
				if (term_neg(2'(n), 2'(k)))
					sum_c[n] = sum_c[n] - SUM_W'(term[n][k]);
				else
					sum_c[n] = sum_c[n] + SUM_W'(term[n][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++)
			sum_s4[n] <= sum_c[n];
	end

	// saturation; the real part of a rotation is forced to zero
	always_comb begin
		for (int n = 0; n < 4; n++)
			ov_c[n] = (sum_s4[n] > SAT_HI) || (sum_s4[n] < SAT_LO);
		if (rot_s4)
			ov_c[0] = 1'b0;
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			if (n == 0 && rot_s4)
				r_s5[n] <= '0;
			else if (sum_s4[n] > SAT_HI)
				r_s5[n] <= SAT_HI[WORD_BITS-1:0];
			else if (sum_s4[n] < SAT_LO)
				r_s5[n] <= SAT_LO[WORD_BITS-1:0];
			else
				r_s5[n] <= sum_s4[n][WORD_BITS-1:0];
		end
		ov_s5 <= ov_c[0] || ov_c[1] || ov_c[2] || ov_c[3];
	end

	assign done     = vld_s5;
	assign r_w      = r_s5[0];
	assign r_x      = r_s5[1];
	assign r_y      = r_s5[2];
	assign r_z      = r_s5[3];
	assign overflow = ov_s5;

	// every result beat comes from an accepted beat
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("done without matching accepted beat");

	// a saturated beat shows at least one component at a limit
	a_ov_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |->
			(r_w == SAT_HI[WORD_BITS-1:0] || r_w == SAT_LO[WORD_BITS-1:0] ||
			 r_x == SAT_HI[WORD_BITS-1:0] || r_x == SAT_LO[WORD_BITS-1:0] ||
			 r_y == SAT_HI[WORD_BITS-1:0] || r_y == SAT_LO[WORD_BITS-1:0] ||
			 r_z == SAT_HI[WORD_BITS-1:0] || r_z == SAT_LO[WORD_BITS-1:0]))
		else $error("overflow set with no saturated component");

	// rotations always deliver a zero real part
	a_rot_w: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_ROTX || action == ACT_ROTY || action == ACT_ROTZ))
			|-> ##5 (done && r_w == '0))
		else $error("rotation result with nonzero real part");

	// unused action codes give an all-zero result without overflow
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action > ACT_ROTZ) |-> ##5
			(done && !overflow && r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0))
		else $error("unused action gave nonzero result");

endmodule

`default_nettype wire

// ===== bench/quat_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the quaternion unit, predicts each result from the
// accepted beat and compares it with what comes out on the result channel.
module quat_result_checker (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire                       busy,
	input  wire  [qmr_pkg::ACT_W-1:0] action,
	input  qmr_pkg::word_t            a_w,
	input  qmr_pkg::word_t            a_x,
	input  qmr_pkg::word_t            a_y,
	input  qmr_pkg::word_t            a_z,
	input  qmr_pkg::word_t            b_w,
	input  qmr_pkg::word_t            b_x,
	input  qmr_pkg::word_t            b_y,
	input  qmr_pkg::word_t            b_z,
	input  wire                       done,
	input  qmr_pkg::word_t            r_w,
	input  qmr_pkg::word_t            r_x,
	input  qmr_pkg::word_t            r_y,
	input  qmr_pkg::word_t            r_z,
	input  wire                       overflow,
	output int                        mismatches,
	output int                        outstanding
);

	import qmr_pkg::*;

	typedef longint quad_t [0:3];

	typedef struct packed {
		word_t w;
		word_t x;
		word_t y;
		word_t z;
		logic  ovf;
	} quat_out_t;

	quat_out_t expected_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// Exact product, rounded half up to FRAC_BITS fraction bits
	function automatic longint round_mul(input longint p, input longint q);
		return (p * q + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	// Clamp a sum to the word range, flag when it had to clamp
	function automatic word_t clamp_word(input longint s, output logic hit);
		longint hi;
		longint lo;
		hi  = (longint'(1) <<< (WORD_BITS - 1)) - 1;
		lo  = -(longint'(1) <<< (WORD_BITS - 1));
		hit = 1'b0;
		if (s > hi) begin
			hit = 1'b1;
			return word_t'(hi);
		end
		if (s < lo) begin
			hit = 1'b1;
			return word_t'(lo);
		end
		return word_t'(s);
	endfunction

	// Hamilton product p*q, unsaturated sums of rounded products
	function automatic void hamilton_sums(input quad_t p, input quad_t q, output quad_t s);
		s[0] = round_mul(p[0], q[0]) - round_mul(p[1], q[1])
		     - round_mul(p[2], q[2]) - round_mul(p[3], q[3]);
		s[1] = round_mul(p[0], q[1]) + round_mul(p[1], q[0])
		     + round_mul(p[2], q[3]) - round_mul(p[3], q[2]);
		s[2] = round_mul(p[0], q[2]) - round_mul(p[1], q[3])
		     + round_mul(p[2], q[0]) + round_mul(p[3], q[1]);
		s[3] = round_mul(p[0], q[3]) + round_mul(p[1], q[2])
		     - round_mul(p[2], q[1]) + round_mul(p[3], q[0]);
	endfunction

	function automatic quat_out_t predict_product(
		input logic [ACT_W-1:0] act,
		input word_t aw, input word_t ax, input word_t ay, input word_t az,
		input word_t bw, input word_t bx, input word_t by, input word_t bz
	);
		quad_t     a;
		quad_t     b;
		quad_t     t;
		quad_t     c;
		quad_t     s;
		logic      h0, h1, h2, h3;
		logic      rot;
		quat_out_t res;
		a   = '{longint'(aw), longint'(ax), longint'(ay), longint'(az)};
		b   = '{longint'(bw), longint'(bx), longint'(by), longint'(bz)};
		c   = '{a[0], -a[1], -a[2], -a[3]};
		res = '0;
		rot = 1'b1;
		// A*e is exact: only permutations and negations of A
		case (act)
			ACT_ROTX: t = '{-a[1], a[0], a[3], -a[2]};
			ACT_ROTY: t = '{-a[2], -a[3], a[0], a[1]};
			ACT_ROTZ: t = '{-a[3], a[2], -a[1], a[0]};
			default:  rot = 1'b0;
		endcase
		if (act == ACT_QQ || act == ACT_QV) begin
			if (act == ACT_QV)
				b[0] = 0;
			hamilton_sums(a, b, s);
			res.w   = clamp_word(s[0], h0);
			res.x   = clamp_word(s[1], h1);
			res.y   = clamp_word(s[2], h2);
			res.z   = clamp_word(s[3], h3);
			res.ovf = h0 | h1 | h2 | h3;
		end else if (rot) begin
			// real part is dropped, and so is its saturation
			hamilton_sums(t, c, s);
			res.x   = clamp_word(s[1], h1);
			res.y   = clamp_word(s[2], h2);
			res.z   = clamp_word(s[3], h3);
			res.ovf = h1 | h2 | h3;
		end
		return res;
	endfunction

	task automatic report_field(input string field, input longint want, input longint got);
		$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Results first, then new beats, so a stray result never eats a fresh expectation
	always @(posedge clk) begin
		quat_out_t want;
		quat_out_t got;
		if (arst_n) begin
			if (done) begin
				got = '{r_w, r_x, r_y, r_z, overflow};
				if (expected_results.size() == 0) begin
					$display("%0t ns: result beat with none expected, actual %0d %0d %0d %0d ov %0d",
						$time, got.w, got.x, got.y, got.z, got.ovf);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.w !== want.w)
						report_field("r_w", want.w, got.w);
					if (got.x !== want.x)
						report_field("r_x", want.x, got.x);
					if (got.y !== want.y)
						report_field("r_y", want.y, got.y);
					if (got.z !== want.z)
						report_field("r_z", want.z, got.z);
					if (got.ovf !== want.ovf)
						report_field("overflow", want.ovf, got.ovf);
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_product(action, a_w, a_x, a_y, a_z,
					b_w, b_x, b_y, b_z));
		end
		outstanding = expected_results.size();
	end

endmodule

// ===== bench/tb_quaternion_multiply_rotate_unit.sv =====
`timescale 1ns / 1ps

module tb_quaternion_multiply_rotate_unit;

	import qmr_pkg::*;

	localparam int    RANDOM_ITEMS = 1400;
	localparam int    CALM_TAIL    = 150;
	localparam int    LIMIT        = 200000;
	localparam word_t W_MIN        = 16'sh8000;
	localparam word_t W_MAX        = 16'sh7fff;
	localparam word_t W_ONE        = 16'sd16384;
	localparam word_t W_HALF       = 16'sd8192;
	localparam word_t W_ZERO       = 16'sd0;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [ACT_W-1:0] action = '0;
	word_t            a_w = '0, a_x = '0, a_y = '0, a_z = '0;
	word_t            b_w = '0, b_x = '0, b_y = '0, b_z = '0;
	logic             done;
	word_t            r_w, r_x, r_y, r_z;
	logic             overflow;
	int               mismatches;
	int               outstanding;
	int               cycles = 0;

	always #1 clk = ~clk;

	quaternion_multiply_rotate_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.a_w      (a_w),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_w      (b_w),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.done     (done),
		.r_w      (r_w),
		.r_x      (r_x),
		.r_y      (r_y),
		.r_z      (r_z),
		.overflow (overflow)
	);

	quat_result_checker check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.a_w         (a_w),
		.a_x         (a_x),
		.a_y         (a_y),
		.a_z         (a_z),
		.b_w         (b_w),
		.b_x         (b_x),
		.b_y         (b_y),
		.b_z         (b_z),
		.done        (done),
		.r_w         (r_w),
		.r_x         (r_x),
		.r_y         (r_y),
		.r_z         (r_z),
		.overflow    (overflow),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one beat at the falling edge and hold it until taken
	task automatic send_beat(
		input logic [ACT_W-1:0] act,
		input word_t aw, input word_t ax, input word_t ay, input word_t az,
		input word_t bw, input word_t bx, input word_t by, input word_t bz
	);
		@(negedge clk);
		action <= act;
		a_w    <= aw;
		a_x    <= ax;
		a_y    <= ay;
		a_z    <= az;
		b_w    <= bw;
		b_x    <= bx;
		b_y    <= by;
		b_z    <= bz;
		start  <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Mix of extremes, small values, near-unit values and full-range noise
	function automatic word_t pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       return W_MIN;
			1:       return W_MAX;
			2:       return word_t'(int'($urandom_range(0, 1023)) - 512);
			3:       return word_t'(($urandom_range(0, 1) ? 16384 : -16384)
			                        + int'($urandom_range(0, 63)) - 32);
			default: return word_t'($urandom);
		endcase
	endfunction

	// Rotation quaternion components, each within about +-0.707 (+-11585 in Q2.14), not normalized
	function automatic word_t pick_rot_word();
		return word_t'(int'($urandom_range(0, 23170)) - 11585);
	endfunction

	initial begin
		logic [ACT_W-1:0] act;
		int               sel;
		word_t            q [0:7];
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: zeros, identity, extremes, rounding ties, unused codes
		send_beat(ACT_QQ, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_QQ, W_ONE, W_ZERO, W_ZERO, W_ZERO, 16'sd1234, -16'sd77, W_MAX, W_MIN);
		send_beat(ACT_QQ, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);
		send_beat(ACT_QQ, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
		send_beat(ACT_QQ, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN);
		send_beat(ACT_QQ, 16'sd1, W_ZERO, W_ZERO, W_ZERO, W_HALF, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_QQ, -16'sd1, W_ZERO, W_ZERO, W_ZERO, W_HALF, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_QQ, -16'sd1, -16'sd1, 16'sd1, 16'sd1, W_HALF, W_HALF, W_HALF, W_HALF);
		send_beat(ACT_QV, W_ONE, W_ZERO, W_ZERO, W_ZERO, W_MAX, 16'sd100, -16'sd200, 16'sd300);
		send_beat(ACT_QV, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, W_MAX, W_MAX);
		send_beat(ACT_QV, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN, W_MIN, W_MIN);
		send_beat(ACT_ROTX, W_ONE, W_ZERO, W_ZERO, W_ZERO, W_MAX, W_MAX, W_MAX, W_MAX);
		send_beat(ACT_ROTY, W_ONE, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTZ, W_ONE, W_ZERO, W_ZERO, W_ZERO, W_MIN, W_MIN, W_MIN, W_MIN);
		send_beat(ACT_ROTX, W_MIN, W_MIN, W_MIN, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTY, W_MIN, W_MIN, W_MIN, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTZ, W_MIN, W_MIN, W_MIN, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTX, W_MAX, W_MAX, W_MAX, W_MAX, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTY, W_MAX, W_MIN, W_MAX, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(ACT_ROTZ, 16'sd11585, W_ZERO, W_ZERO, 16'sd11585,
			W_ZERO, W_ZERO, W_ZERO, W_ZERO);
		send_beat(3'd5, W_MAX, W_MIN, W_ONE, W_HALF, W_MAX, W_MIN, W_ONE, W_HALF);
		send_beat(3'd6, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
		send_beat(3'd7, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX);

		// Random beats with idle bursts, a calm stretch at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sel = $urandom_range(0, 31);
			act = (sel < 2) ? 3'($urandom_range(5, 7)) : 3'(sel % 5);
			for (int k = 0; k < 8; k++)
				q[k] = pick_word();
			if ((act == ACT_ROTX || act == ACT_ROTY || act == ACT_ROTZ)
			    && $urandom_range(0, 1))
				for (int k = 0; k < 4; k++)
					q[k] = pick_rot_word();
			send_beat(act, q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
			if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain, then wait on to catch stray result beats
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
